[rtl/core/rx_fifo_watermark_flow_control_defines.svh]
// Assertion helpers shared by the receive FIFO modules.
// Every check runs on clk_i and is disabled while rst_ni is low.
`ifndef RX_FIFO_WATERMARK_FLOW_CONTROL_DEFINES_SVH
`define RX_FIFO_WATERMARK_FLOW_CONTROL_DEFINES_SVH

// Checks a property on the rising edge of clk_i, outside of reset.
`define RXWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next cycle.
`define RXWM_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/core/rxwm_pkg.sv]
`default_nettype none

package rxwm_pkg;

  // Field widths of the channels.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MarkW   = 11;
  localparam int unsigned CfgIdxW = 2;

  // Default storage depth in bytes.
  localparam int unsigned DefaultDepth = 1024;

  // Watermark values after reset.
  localparam logic [MarkW-1:0] HighMarkReset = 11'd1000;
  localparam logic [MarkW-1:0] LowMarkReset  = 11'd100;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_HIGH_MARK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_MARK  = 2'd1;

  // Operation carried by an input transaction.
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } act_e;

  // Error code reported with every result.
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2
  } err_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the item and start the storage read
    logic exec;  // apply the item and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result in this cycle
  } status_t;

endpackage

`default_nettype wire

[rtl/core/rxwm_if.sv]
`default_nettype none

// Input channel: one push or pop request per transaction.
interface rxwm_in_if
  import rxwm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// Result channel: one result per input transaction.
interface rxwm_out_if
  import rxwm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             out_valid;
  logic             lock;
  logic [MarkW-1:0] fill_count;
  logic [1:0]       error;

  modport source (output valid, output out_byte, output out_valid, output lock,
                  output fill_count, output error, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input lock,
                  input fill_count, input error, output ready);
endinterface

// Configuration write channel.
interface rxwm_cfg_if
  import rxwm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] addr;
  logic [MarkW-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/rxwm_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module rxwm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and held while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rxwm_ctrl.sv]
`default_nettype none

// Sequencer: takes one item, then applies it once the output register is free.
module rxwm_ctrl
  import rxwm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Command decode.
  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec = (state_q == ST_EXEC) && status_i.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rxwm_dp.sv]
`default_nettype none
`include "rx_fifo_watermark_flow_control_defines.svh"

// Datapath: byte storage, pointers, fill count, lock, marks and output register.
module rxwm_dp
  import rxwm_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  input  wire logic               action_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_addr_i,
  input  wire logic [MarkW-1:0]   cfg_data_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic      [ByteW-1:0]   out_byte_o,
  output logic                    out_valid_o,
  output logic                    lock_o,
  output logic      [MarkW-1:0]   fill_count_o,
  output logic      [1:0]         error_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > MarkW) ? CntW : MarkW;

  // Watermark registers.
  logic [MarkW-1:0] high_mark_q, low_mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_mark_q <= HighMarkReset;
      low_mark_q  <= LowMarkReset;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_HIGH_MARK) begin
        high_mark_q <= cfg_data_i;
      end
      if (cfg_addr_i == CFG_LOW_MARK) begin
        low_mark_q <= cfg_data_i;
      end
    end
  end

  // Captured item.
  logic             act_q;
  logic [ByteW-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      byte_q <= rx_byte_i;
    end
  end

  // FIFO state.
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            lock_q, lock_d;
  logic [ByteW-1:0] rdata;
  logic            full, empty, mem_we;
  logic [ByteW-1:0] res_byte;
  logic            res_pop_ok;
  err_e            res_err;

  assign full  = (cnt_q == CntW'(DEPTH));
  assign empty = (cnt_q == '0);

  // Byte storage; the read is started when the item is captured.
  rxwm_ram #(
    .Width (ByteW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (byte_q),
    .re_i    (cmd_i.load),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // Push and pop update, with the hysteresis tests on the new count.
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    lock_d     = lock_q;
    mem_we     = 1'b0;
    res_byte   = '0;
    res_pop_ok = 1'b0;
    res_err    = ERR_NONE;
    if (cmd_i.exec) begin
      if (act_q == ACT_PUSH) begin
        if (full) begin
          res_err = ERR_OVERFLOW;
        end else begin
          mem_we   = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
        if (CmpW'(cnt_d) > CmpW'(high_mark_q)) begin
          lock_d = 1'b1;
        end
      end else begin
        if (empty) begin
          res_err = ERR_UNDERFLOW;
        end else begin
          res_byte   = rdata;
          res_pop_ok = 1'b1;
          rd_ptr_d   = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
          cnt_d      = cnt_q - 1'b1;
          if (CmpW'(cnt_d) < CmpW'(low_mark_q)) begin
            lock_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      lock_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      lock_q   <= lock_d;
    end
  end

  // Output register.
  logic res_vld_q;

  assign status_o.out_free = !res_vld_q || res_ready_i;
  assign res_valid_o       = res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (cmd_i.exec) begin
      res_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_byte_o   <= res_byte;
      out_valid_o  <= res_pop_ok;
      lock_o       <= lock_d;
      fill_count_o <= MarkW'(cnt_d);
      error_o      <= res_err;
    end
  end

  // The fill count never passes the storage depth.
  `RXWM_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH), "fill count above depth")
  // A successful pop lowers the count by exactly one.
  `RXWM_ASSERT_NEXT(a_pop_dec, cmd_i.exec && act_q == ACT_POP && !empty,
                    cnt_q == $past(cnt_q) - 1'b1, "pop did not decrement the count")
  // The lock is raised only by a push.
  `RXWM_ASSERT(a_lock_push, $rose(lock_q) |-> $past(cmd_i.exec && act_q == ACT_PUSH),
               "lock raised without a push")
  // A waiting result is never overwritten.
  `RXWM_ASSERT(a_no_overrun, cmd_i.exec |-> (!res_vld_q || res_ready_i),
               "result register overwritten")

endmodule

`default_nettype wire

[rtl/core/rx_fifo_watermark_flow_control.sv]
// Receive byte FIFO with watermark flow control.
// Channel in_i carries one request per transaction: action 0 pushes rx_byte,
// action 1 pops the oldest stored byte. Channel out_o returns exactly one
// result per request: the popped byte with its flag, the lock level, the
// fill count after the request and an error code (overflow on a push into
// a full FIFO, underflow on a pop from an empty one). Channel cfg_i writes
// the high mark (index 0) and the low mark (index 1); it is always ready.
// A push that leaves more bytes than the high mark raises lock; a pop that
// leaves fewer than the low mark drops it.
// Each request is captured and its storage read started; once the output
// register is free, the request is applied and the output register loaded.
// A new request is taken only after the previous one has been applied.
// While a result waits on out_o, one further request is accepted and held
// until the output register frees up; the storage is not touched in the
// meantime. Reset empties the FIFO, releases the lock, restores the marks
// to 1000 and 100 and needs no clearing pass; storage contents are unknown.
`default_nettype none

module rx_fifo_watermark_flow_control
  import rxwm_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rxwm_in_if.sink   in_i,
  rxwm_out_if.source out_o,
  rxwm_cfg_if.sink  cfg_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  // Sequencer.
  rxwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  rxwm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .action_i     (in_i.action),
    .rx_byte_i    (in_i.rx_byte),
    .cfg_we_i     (cfg_i.valid),
    .cfg_addr_i   (cfg_i.addr),
    .cfg_data_i   (cfg_i.data),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .out_valid_o  (out_o.out_valid),
    .lock_o       (out_o.lock),
    .fill_count_o (out_o.fill_count),
    .error_o      (out_o.error)
  );

endmodule

`default_nettype wire
